// File: sv/rwbs_pkg.sv
package rwbs_pkg;

  localparam int unsigned TIME_W = 64;
  localparam int unsigned QOS_W  = 2;

  typedef logic [TIME_W-1:0] time_ns_t;
  typedef logic [QOS_W-1:0]  qos_t;

  // QoS ranks, higher is preferred
  localparam qos_t QOS_LATENCY    = qos_t'(3);
  localparam qos_t QOS_DEFAULT    = qos_t'(2);
  localparam qos_t QOS_THROUGHPUT = qos_t'(1);
  localparam qos_t QOS_BACKGROUND = qos_t'(0);

  // One step of the pass: take judges the staged candidate, close ends the pass
  typedef struct packed {
    logic take;
    logic close;
  } step_ctl_t;

endpackage

// File: sv/ready_work_best_selector.sv
// A beat that closes a pass goes through one input register and one result register;
//   it waits in the input register while the result register is full.
// Throughput: one candidate per cycle; the compare-and-update of the held best is combinational,
//   and only a full result register stalls a closing beat.
// Reset (rst_n, synchronous, active low): clears all valid flags and the held best,
//   and sets cost tie-break to enabled.
module ready_work_best_selector
  import rwbs_pkg::*;
#(
  parameter int unsigned PRIORITY_WIDTH = 8,
  parameter int unsigned ID_WIDTH       = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_eligible,
  input  logic [PRIORITY_WIDTH-1:0] in_priority_req,
  input  logic                      in_has_deadline,
  input  time_ns_t                  in_deadline_ns,
  input  qos_t                      in_qos_rank,
  input  time_ns_t                  in_duration_ns,
  input  time_ns_t                  in_cost_ns,
  input  logic [ID_WIDTH-1:0]       in_work_id,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output logic [ID_WIDTH-1:0]       out_winner_id,
  output time_ns_t                  out_winner_cost_ns
);

  logic                      cost_en_r;

  logic                      stg_valid_r;
  logic                      stg_elig_r;
  logic [PRIORITY_WIDTH-1:0] stg_prio_r;
  logic                      stg_has_dl_r;
  time_ns_t                  stg_dl_r;
  qos_t                      stg_qos_r;
  time_ns_t                  stg_dur_r;
  time_ns_t                  stg_cost_r;
  logic [ID_WIDTH-1:0]       stg_id_r;
  logic                      stg_last_r;

  logic                      step;
  logic                      out_free;
  step_ctl_t                 ctl;
  logic                      wins;

  logic                      have_best;
  logic [PRIORITY_WIDTH-1:0] best_prio;
  logic                      best_has_dl;
  time_ns_t                  best_dl;
  qos_t                      best_rank;
  time_ns_t                  best_dur;
  time_ns_t                  best_cost;
  logic [ID_WIDTH-1:0]       best_id;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_en_r <= 1'b1;
    end else if (cfg_we) begin
      cost_en_r <= cfg_wdata;
    end
  end

  // A closing beat waits for room in the result register; others advance at once
  assign step      = stg_valid_r && (!stg_last_r || out_free);
  assign in_ready  = !stg_valid_r || step;
  assign ctl.take  = step && stg_elig_r;
  assign ctl.close = step && stg_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_elig_r   <= in_eligible;
      stg_prio_r   <= in_priority_req;
      stg_has_dl_r <= in_has_deadline;
      stg_dl_r     <= in_deadline_ns;
      stg_qos_r    <= in_qos_rank;
      stg_dur_r    <= in_duration_ns;
      stg_cost_r   <= in_cost_ns;
      stg_id_r     <= in_work_id;
      stg_last_r   <= in_last;
    end
  end

  rwbs_cmp #(
    .PRIORITY_WIDTH (PRIORITY_WIDTH),
    .ID_WIDTH       (ID_WIDTH)
  ) u_cmp (
    .have_best   (have_best),
    .cost_en     (cost_en_r),
    .cand_prio   (stg_prio_r),
    .cand_has_dl (stg_has_dl_r),
    .cand_dl     (stg_dl_r),
    .cand_qos    (stg_qos_r),
    .cand_dur    (stg_dur_r),
    .cand_cost   (stg_cost_r),
    .cand_id     (stg_id_r),
    .best_prio   (best_prio),
    .best_has_dl (best_has_dl),
    .best_dl     (best_dl),
    .best_rank   (best_rank),
    .best_dur    (best_dur),
    .best_cost   (best_cost),
    .best_id     (best_id),
    .wins        (wins)
  );

  rwbs_keep #(
    .PRIORITY_WIDTH (PRIORITY_WIDTH),
    .ID_WIDTH       (ID_WIDTH)
  ) u_keep (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .wins               (wins),
    .cand_prio          (stg_prio_r),
    .cand_has_dl        (stg_has_dl_r),
    .cand_dl            (stg_dl_r),
    .cand_qos           (stg_qos_r),
    .cand_dur           (stg_dur_r),
    .cand_cost          (stg_cost_r),
    .cand_id            (stg_id_r),
    .have_best          (have_best),
    .best_prio          (best_prio),
    .best_has_dl        (best_has_dl),
    .best_dl            (best_dl),
    .best_rank          (best_rank),
    .best_dur           (best_dur),
    .best_cost          (best_cost),
    .best_id            (best_id),
    .out_free           (out_free),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_winner_id      (out_winner_id),
    .out_winner_cost_ns (out_winner_cost_ns)
  );

endmodule

// File: sv/rwbs_cmp.sv
module rwbs_cmp
  import rwbs_pkg::*;
#(
  parameter int unsigned PRIORITY_WIDTH = 8,
  parameter int unsigned ID_WIDTH       = 16
) (
  input  logic                      have_best,
  input  logic                      cost_en,
  input  logic [PRIORITY_WIDTH-1:0] cand_prio,
  input  logic                      cand_has_dl,
  input  time_ns_t                  cand_dl,
  input  qos_t                      cand_qos,
  input  time_ns_t                  cand_dur,
  input  time_ns_t                  cand_cost,
  input  logic [ID_WIDTH-1:0]       cand_id,
  input  logic [PRIORITY_WIDTH-1:0] best_prio,
  input  logic                      best_has_dl,
  input  time_ns_t                  best_dl,
  input  qos_t                      best_rank,
  input  time_ns_t                  best_dur,
  input  time_ns_t                  best_cost,
  input  logic [ID_WIDTH-1:0]       best_id,
  output logic                      wins
);

  logic dur_known;

  assign dur_known = (cand_dur != '0) && (best_dur != '0);

  // Keys are compared in parallel; the first key that differs decides
  always_comb begin
    if (!have_best) begin
      wins = 1'b1;
    end else if (cand_prio != best_prio) begin
      wins = cand_prio > best_prio;
    end else if (cand_has_dl != best_has_dl) begin
      wins = cand_has_dl;
    end else if (cand_has_dl && (cand_dl != best_dl)) begin
      wins = cand_dl < best_dl;
    end else if (cand_qos != best_rank) begin
      wins = cand_qos > best_rank;
    end else if (dur_known && (cand_dur != best_dur)) begin
      wins = cand_dur < best_dur;
    end else if (cost_en && (cand_cost != best_cost)) begin
      wins = cand_cost < best_cost;
    end else begin
      wins = cand_id < best_id;
    end
  end

endmodule

// File: sv/rwbs_keep.sv
module rwbs_keep
  import rwbs_pkg::*;
#(
  parameter int unsigned PRIORITY_WIDTH = 8,
  parameter int unsigned ID_WIDTH       = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  step_ctl_t                 ctl,
  input  logic                      wins,
  input  logic [PRIORITY_WIDTH-1:0] cand_prio,
  input  logic                      cand_has_dl,
  input  time_ns_t                  cand_dl,
  input  qos_t                      cand_qos,
  input  time_ns_t                  cand_dur,
  input  time_ns_t                  cand_cost,
  input  logic [ID_WIDTH-1:0]       cand_id,
  output logic                      have_best,
  output logic [PRIORITY_WIDTH-1:0] best_prio,
  output logic                      best_has_dl,
  output time_ns_t                  best_dl,
  output qos_t                      best_rank,
  output time_ns_t                  best_dur,
  output time_ns_t                  best_cost,
  output logic [ID_WIDTH-1:0]       best_id,
  output logic                      out_free,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output logic [ID_WIDTH-1:0]       out_winner_id,
  output time_ns_t                  out_winner_cost_ns
);

  logic                      have_best_r;
  logic [PRIORITY_WIDTH-1:0] best_prio_r;
  logic                      best_has_dl_r;
  time_ns_t                  best_dl_r;
  qos_t                      best_rank_r;
  time_ns_t                  best_dur_r;
  time_ns_t                  best_cost_r;
  logic [ID_WIDTH-1:0]       best_id_r;

  logic                      out_valid_r;
  logic                      out_found_r;
  logic [ID_WIDTH-1:0]       out_id_r;
  time_ns_t                  out_cost_r;

  logic                      upd;
  logic                      have_nxt;
  logic [ID_WIDTH-1:0]       id_nxt;
  time_ns_t                  cost_nxt;

  assign upd      = ctl.take && wins;
  assign have_nxt = upd || have_best_r;
  assign id_nxt   = upd ? cand_id : best_id_r;
  assign cost_nxt = upd ? cand_cost : best_cost_r;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
    end else if (ctl.close) begin
      have_best_r <= 1'b0;
    end else if (upd) begin
      have_best_r <= 1'b1;
    end
  end

  // Payload of the held best needs no clearing: have_best gates it
  always_ff @(posedge clk) begin
    if (upd) begin
      best_prio_r   <= cand_prio;
      best_has_dl_r <= cand_has_dl;
      best_dl_r     <= cand_dl;
      best_rank_r   <= cand_qos;
      best_dur_r    <= cand_dur;
      best_cost_r   <= cand_cost;
      best_id_r     <= cand_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.close) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.close) begin
      out_found_r <= have_nxt;
      out_id_r    <= have_nxt ? id_nxt : '0;
      out_cost_r  <= have_nxt ? cost_nxt : '0;
    end
  end

  assign have_best          = have_best_r;
  assign best_prio          = best_prio_r;
  assign best_has_dl        = best_has_dl_r;
  assign best_dl            = best_dl_r;
  assign best_rank          = best_rank_r;
  assign best_dur           = best_dur_r;
  assign best_cost          = best_cost_r;
  assign best_id            = best_id_r;
  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_winner_id      = out_id_r;
  assign out_winner_cost_ns = out_cost_r;

`ifndef NO_ASSERTIONS
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.close |=> !have_best_r)
    else $error("held best survived the end of a pass");

  a_take_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.take && !ctl.close) |=> have_best_r)
    else $error("eligible beat left no held best");

  a_close_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.close |-> out_free)
    else $error("pass closed while the result register was full");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> ((out_id_r == '0) && (out_cost_r == '0)))
    else $error("empty result carries a nonzero winner");
`endif

endmodule
